FILE: sv/tpf_pkg.sv
// Shared types and constants for the trapezoidal profile feedforward block.
// No dependencies; imported by tpf_div, trapezoidal_profile_feedforward and the testbench.
package tpf_pkg;

  // Input word: restart flag and time step.
  typedef struct packed {
    logic        restart;
    logic [15:0] tick_time;
  } tpf_in_t;

  // Output word: Q4.12 drive, Q16.16 velocity, profile phase.
  typedef struct packed {
    logic signed [15:0] drive_level;
    logic signed [31:0] velocity_target;
    logic [1:0]         phase;
  } tpf_out_t;

  // Configuration port geometry and register indexes.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_TARGET     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VEL    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ACC    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VOLT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BEMF       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TIME_SCALE = 3'd5;

  // Profile phase codes.
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_PAST   = 2'd3;

  // ceil(2^33 / 3): x*Div3Recip >> 33 is floor(x/3) for any 32-bit x.
  localparam logic [31:0] Div3Recip = 32'hAAAA_AAAB;

  // Divider geometry: 64-bit dividend, 37-bit divisor and remainder.
  localparam int unsigned DivDvdW = 64;
  localparam int unsigned DivRemW = 37;
  localparam int unsigned DivCntW = 7;

  localparam logic [DivCntW-1:0] DIV_ITERS_FULL = 7'd64;
  // Ratio terms scaled by 4096 never exceed 4096, so 13 quotient bits do.
  localparam logic [DivCntW-1:0] DIV_ITERS_FRAC = 7'd13;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] iters;
    logic [DivRemW-1:0] rem_init;
    logic [DivDvdW-1:0] dvd;
    logic [DivRemW-1:0] divisor;
  } tpf_div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DivDvdW-1:0] quot;
  } tpf_div_rsp_t;

endpackage

FILE: sv/tpf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tpf_pkg for the request and response structs.
module tpf_div
  import tpf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tpf_div_req_t req_i,
  output tpf_div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivRemW-1:0] rem_q, rem_d;
  logic [DivRemW-1:0] divisor_q;
  logic [DivDvdW-1:0] dvd_q;
  logic [DivDvdW-1:0] quot_q;

  logic [DivRemW:0]   shifted;
  logic [DivRemW+1:0] diff;
  logic               fits;

  // Partial remainder stays below the divisor, so one compare-subtract a step.
  assign shifted = {rem_q, dvd_q[DivDvdW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
  assign fits    = ~diff[DivRemW+1];
  assign rem_d   = fits ? diff[DivRemW-1:0] : shifted[DivRemW-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.rem_init;
      dvd_q     <= req_i.dvd;
      divisor_q <= req_i.divisor;
      quot_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[DivDvdW-2:0], 1'b0};
      quot_q <= {quot_q[DivDvdW-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: sv/trapezoidal_profile_feedforward.sv
// Tick word: phase step, the 13-step divide of v*4096/max_velocity, output register (held
// while the output is full); in_ready_o is high again in the same cycle as out_valid_o.
// Register write: the profile (T, acceleration, cruise, scaled terms) is rebuilt through the
// shared multiplier and divider (the acceleration divide is skipped unless 0 < T < 2^18),
// in_ready_o low meanwhile; a new write restarts it.
// Reset (async, active low): registers to their defaults, elapsed time and profile to zero.
// Depends on tpf_pkg and tpf_div.
module trapezoidal_profile_feedforward
  import tpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tick words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpf_in_t             in_data_i,
  // feedforward words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpf_out_t            out_data_o,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // One-hot sequencer. The first group handles a tick word, the second
  // rebuilds the profile after a register write.
  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_PH     = 18'h00002,
    S_VDIV   = 18'h00004,
    S_VWAIT  = 18'h00008,
    S_OUT    = 18'h00010,
    S_TMUL   = 18'h00020,
    S_TDIV   = 18'h00040,
    S_TWAIT  = 18'h00080,
    S_SQ     = 18'h00100,
    S_ADIV   = 18'h00200,
    S_AWAIT  = 18'h00400,
    S_CMUL   = 18'h00800,
    S_CRCP   = 18'h01000,
    S_CFIN   = 18'h02000,
    S_ATDIV  = 18'h04000,
    S_ATWAIT = 18'h08000,
    S_BTDIV  = 18'h10000,
    S_BTWAIT = 18'h20000
  } tpf_state_e;

  tpf_state_e state_q, state_d;

  // Configuration registers
  logic [31:0] target_q;
  logic [30:0] max_vel_q;
  logic [30:0] max_acc_q;
  logic [15:0] max_volt_q;
  logic [15:0] bemf_q;
  logic [15:0] tscale_q;

  // Profile derived from the registers
  logic [31:0] t_total_q;   // move time T in ticks
  logic [30:0] a_mag_q;     // |acceleration|, Q16.16 per tick
  logic        a_neg_q;     // direction of the move
  logic [30:0] cruise_q;    // min(|a|*T/3, max_velocity)
  logic [12:0] aterm_q;     // |a|*4096/max_acceleration
  logic [27:0] bterm_q;     // back_emf*4096/max_voltage

  // Per-word state
  logic [31:0] elapsed_q;
  logic [1:0]  ph_q;
  logic [30:0] m_q;         // clamped velocity magnitude

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_d, prod_q;

  // Shared divider
  tpf_div_req_t div_req;
  tpf_div_rsp_t div_rsp;

  // Output register
  logic     out_valid_q;
  tpf_out_t out_data_q;
  logic     out_free;

  // Limits that read zero act as one
  logic [30:0] max_vel1, max_acc1;
  logic [15:0] max_volt1;

  logic        target_neg;
  logic [31:0] target_mag;
  logic [34:0] num9;        // 9*|target|
  logic [51:0] tnum;        // 9*|target|*time_scale

  logic        in_fire;
  logic        cfg_hit;

  assign max_vel1   = (max_vel_q == '0) ? 31'd1 : max_vel_q;
  assign max_acc1   = (max_acc_q == '0) ? 31'd1 : max_acc_q;
  assign max_volt1  = (max_volt_q == '0) ? 16'd1 : max_volt_q;

  assign target_neg = target_q[31];
  assign target_mag = target_neg ? (~target_q + 32'd1) : target_q;
  assign num9       = {target_mag, 3'b000} + {3'b000, target_mag};
  assign tnum       = {1'b0, prod_q[47:0], 3'b000} + {4'b0000, prod_q[47:0]};

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    case (cfg_idx_i)
      CFG_TARGET, CFG_MAX_VEL, CFG_MAX_ACC,
      CFG_MAX_VOLT, CFG_BEMF, CFG_TIME_SCALE: cfg_hit = cfg_we_i;
      default:                                cfg_hit = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= 32'd0;
      max_vel_q  <= 31'd65536;
      max_acc_q  <= 31'd65536;
      max_volt_q <= 16'd12000;
      bemf_q     <= 16'd0;
      tscale_q   <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET:     target_q   <= cfg_wdata_i;
        CFG_MAX_VEL:    max_vel_q  <= cfg_wdata_i[30:0];
        CFG_MAX_ACC:    max_acc_q  <= cfg_wdata_i[30:0];
        CFG_MAX_VOLT:   max_volt_q <= cfg_wdata_i[15:0];
        CFG_BEMF:       bemf_q     <= cfg_wdata_i[15:0];
        CFG_TIME_SCALE: tscale_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Elapsed time and phase selection
  // ---------------------------------------------------------------------------
  logic [31:0] e_base;
  logic [32:0] e_sum;
  logic [31:0] e_next;
  logic [33:0] e3, t1, t2;
  logic [1:0]  ph_d;
  logic [31:0] ph_x;        // multiplier operand for the ramp phases

  assign e_base = in_data_i.restart ? 32'd0 : elapsed_q;
  assign e_sum  = {1'b0, e_base} + {17'd0, in_data_i.tick_time};
  assign e_next = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];

  // Exact tests: 3e < T, 3e < 2T, e < T
  assign e3 = {2'b00, elapsed_q} + {1'b0, elapsed_q, 1'b0};
  assign t1 = {2'b00, t_total_q};
  assign t2 = {1'b0, t_total_q, 1'b0};

  always_comb begin
    if (e3 < t1) begin
      ph_d = PH_ACCEL;
      ph_x = elapsed_q;
    end else if (e3 < t2) begin
      ph_d = PH_CRUISE;
      ph_x = 32'd0;
    end else if (elapsed_q < t_total_q) begin
      ph_d = PH_DECEL;
      ph_x = t_total_q - elapsed_q;
    end else begin
      ph_d = PH_PAST;
      ph_x = 32'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier, registered product
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      S_TMUL: begin
        mul_a = target_mag;
        mul_b = {16'd0, tscale_q};
      end
      S_SQ: begin
        mul_a = t_total_q;
        mul_b = t_total_q;
      end
      S_CMUL: begin
        mul_a = {1'b0, a_mag_q};
        mul_b = t_total_q;
      end
      S_CRCP: begin
        // floor(P/2)/3 by reciprocal; only P < 2^33 can land below the clamp
        mul_a = prod_q[32:1];
        mul_b = Div3Recip;
      end
      S_PH: begin
        mul_a = {1'b0, a_mag_q};
        mul_b = ph_x;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod_d = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------------------
  // Cruise level |a|*T/3. With P = 2y + b and y = 3q + r,
  // P/3 = 2q + (2r + b)/3, where (2r + b)/3 is 0 or 1.
  // ---------------------------------------------------------------------------
  logic        c_big_q;     // P >= 2^33: quotient is past any velocity limit
  logic [2:0]  c_lo_q;      // P[2:0]
  logic [1:0]  c_rem;
  logic        c_up;
  logic [31:0] c_quot;

  assign c_rem  = c_lo_q[2:1] - (prod_q[34:33] + {prod_q[33], 1'b0});
  assign c_up   = ({c_rem, c_lo_q[0]} >= 3'd3);
  assign c_quot = {prod_q[63:33], c_up};

  // ---------------------------------------------------------------------------
  // Velocity magnitude: ramp product, cruise level or zero, clamped
  // ---------------------------------------------------------------------------
  logic [63:0] m_raw;
  logic [30:0] m_d;

  always_comb begin
    case (ph_q)
      PH_ACCEL, PH_DECEL: m_raw = prod_q;
      PH_CRUISE:          m_raw = {33'd0, cruise_q};
      default:            m_raw = 64'd0;
    endcase
  end

  assign m_d = (m_raw > {33'd0, max_vel1}) ? max_vel1 : m_raw[30:0];

  // The acceleration magnitude test only divides when T < 2^18; beyond that
  // T*T exceeds 9*|target| and the quotient is zero.
  logic t_small;
  assign t_small = (t_total_q != 32'd0) && (t_total_q[31:18] == '0);

  // ---------------------------------------------------------------------------
  // Divider requests
  // ---------------------------------------------------------------------------
  always_comb begin
    div_req          = '0;
    div_req.iters    = DIV_ITERS_FULL;
    case (state_q)
      S_TDIV: begin
        // T = 9*|target|*time_scale / (2*max_velocity)
        div_req.start   = 1'b1;
        div_req.dvd     = {12'd0, tnum};
        div_req.divisor = {5'd0, max_vel1, 1'b0};
      end
      S_ADIV: begin
        // |a| = 9*|target| / (2*T*T)
        div_req.start   = t_small;
        div_req.dvd     = {29'd0, num9};
        div_req.divisor = {prod_q[35:0], 1'b0};
      end
      S_ATDIV: begin
        // |a|*4096 / max_acceleration, dividend pre-aligned for 13 steps
        div_req.start    = 1'b1;
        div_req.iters    = DIV_ITERS_FRAC;
        div_req.rem_init = {7'd0, a_mag_q[30:1]};
        div_req.dvd      = {a_mag_q[0], 63'd0};
        div_req.divisor  = {6'd0, max_acc1};
      end
      S_BTDIV: begin
        div_req.start   = 1'b1;
        div_req.dvd     = {36'd0, bemf_q, 12'd0};
        div_req.divisor = {21'd0, max_volt1};
      end
      S_VDIV: begin
        // |v|*4096 / max_velocity
        div_req.start    = 1'b1;
        div_req.iters    = DIV_ITERS_FRAC;
        div_req.rem_init = {7'd0, m_d[30:1]};
        div_req.dvd      = {m_d[0], 63'd0};
        div_req.divisor  = {6'd0, max_vel1};
      end
      default: ;
    endcase
  end

  tpf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_PH;
      S_PH:     state_d = S_VDIV;
      S_VDIV:   state_d = S_VWAIT;
      S_VWAIT:  if (!div_rsp.busy) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      S_TMUL:   state_d = S_TDIV;
      S_TDIV:   state_d = S_TWAIT;
      S_TWAIT:  if (!div_rsp.busy) state_d = S_SQ;
      S_SQ:     state_d = S_ADIV;
      S_ADIV:   state_d = t_small ? S_AWAIT : S_CMUL;
      S_AWAIT:  if (!div_rsp.busy) state_d = S_CMUL;
      S_CMUL:   state_d = S_CRCP;
      S_CRCP:   state_d = S_CFIN;
      S_CFIN:   state_d = S_ATDIV;
      S_ATDIV:  state_d = S_ATWAIT;
      S_ATWAIT: if (!div_rsp.busy) state_d = S_BTDIV;
      S_BTDIV:  state_d = S_BTWAIT;
      S_BTWAIT: if (!div_rsp.busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    // Any register write rebuilds the profile from scratch.
    if (cfg_hit) begin
      state_d = S_TMUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Profile and elapsed-time state (reset matches the default registers:
  // zero target gives T = 0, a = 0; zero back emf gives a zero term)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= 32'd0;
      t_total_q <= 32'd0;
      a_mag_q   <= 31'd0;
      a_neg_q   <= 1'b0;
      cruise_q  <= 31'd0;
      aterm_q   <= 13'd0;
      bterm_q   <= 28'd0;
    end else begin
      if (in_fire && !cfg_hit) begin
        elapsed_q <= e_next;
      end
      case (state_q)
        S_TWAIT: begin
          if (!div_rsp.busy) begin
            t_total_q <= (div_rsp.quot[63:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quot[31:0];
          end
        end
        S_ADIV: begin
          a_neg_q <= target_neg;
          if (!t_small) begin
            a_mag_q <= 31'd0;
          end
        end
        S_AWAIT: begin
          if (!div_rsp.busy) begin
            a_mag_q <= (div_rsp.quot > {33'd0, max_acc1}) ? max_acc1 : div_rsp.quot[30:0];
          end
        end
        S_CFIN: begin
          cruise_q <= (c_big_q || c_quot > {1'b0, max_vel1}) ? max_vel1 : c_quot[30:0];
        end
        S_ATWAIT: begin
          if (!div_rsp.busy) begin
            aterm_q <= div_rsp.quot[12:0];
          end
        end
        S_BTWAIT: begin
          if (!div_rsp.busy) begin
            bterm_q <= div_rsp.quot[27:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PH) begin
      ph_q <= ph_d;
    end
    if (state_q == S_VDIV) begin
      m_q <= m_d;
    end
    if (state_q == S_CRCP) begin
      c_big_q <= |prod_q[63:33];
      c_lo_q  <= prod_q[2:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Drive sum: each term truncates toward zero, then Q4.12 saturation
  // ---------------------------------------------------------------------------
  logic [13:0]        vterm_mag, aterm_mag;
  logic signed [13:0] vterm, aterm;
  logic signed [30:0] drive_sum;
  logic signed [15:0] drive_sat;
  logic signed [31:0] vel_signed;

  assign vterm_mag  = {1'b0, div_rsp.quot[12:0]};
  assign aterm_mag  = {1'b0, aterm_q};
  assign vterm      = a_neg_q ? -$signed(vterm_mag) : $signed(vterm_mag);
  assign aterm      = a_neg_q ? -$signed(aterm_mag) : $signed(aterm_mag);
  assign drive_sum  = 31'(vterm) + 31'(aterm) + $signed({3'b000, bterm_q});
  assign vel_signed = a_neg_q ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});

  always_comb begin
    if (drive_sum > 31'sd32767) begin
      drive_sat = 16'sh7FFF;
    end else if (drive_sum < -31'sd32768) begin
      drive_sat = 16'sh8000;
    end else begin
      drive_sat = drive_sum[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_data_q.drive_level     <= drive_sat;
      out_data_q.velocity_target <= vel_signed;
      out_data_q.phase           <= ph_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_ready_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("ready while divider busy");

  a_accept_to_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_hit) |=> (state_q == S_PH))
    else $error("accepted word did not start phase step");

  a_past_end_stopped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.phase == PH_PAST) |-> (out_data_o.velocity_target == 32'sd0))
    else $error("nonzero velocity past end of profile");

  a_profile_limits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (a_mag_q <= max_acc1 && cruise_q <= max_vel1))
    else $error("derived profile exceeds its limits");
`endif

endmodule

FILE: tb/sv/tpf_feedforward_checker.sv
`timescale 1ns / 1ps
// Scoreboard for trapezoidal_profile_feedforward: watches the tick, feedforward and register ports,
// predicts each feedforward word from its own copy of the registers and profile, and compares.
// Depends on tpf_pkg.
module tpf_feedforward_checker
  import tpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  tpf_in_t             in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tpf_out_t            out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam longint Q12One   = 4096;
  localparam longint DriveMax = 32767;
  localparam longint DriveMin = -32768;

  // register copy
  logic [31:0] r_target;
  logic [30:0] r_vmax;
  logic [30:0] r_amax;
  logic [15:0] r_volt;
  logic [15:0] r_bemf;
  logic [15:0] r_tscale;

  // derived profile and running time
  logic [31:0]        move_ticks;
  logic signed [31:0] prof_acc;
  logic [31:0]        elapsed;

  tpf_out_t drive_q[$];
  int       errors;

  function automatic logic [63:0] nonzero(logic [63:0] x);
    return (x == 64'd0) ? 64'd1 : x;
  endfunction

  // Move time T and signed profile acceleration from the registers.
  function automatic void rebuild_profile();
    logic [63:0] tgt64, mag, num, tt, q, acc_lim;
    logic        neg;
    tgt64   = {{32{r_target[31]}}, r_target};
    neg     = r_target[31];
    mag     = neg ? -tgt64 : tgt64;
    num     = 64'd9 * mag;
    tt      = num * {48'd0, r_tscale} / (64'd2 * nonzero({33'd0, r_vmax}));
    acc_lim = nonzero({33'd0, r_amax});
    if (tt > 64'hFFFF_FFFF) tt = 64'hFFFF_FFFF;
    move_ticks = tt[31:0];
    if (tt == 64'd0) begin
      prof_acc = '0;
    end else begin
      q = (num / (tt * tt)) / 64'd2;
      if (q > acc_lim) q = acc_lim;
      prof_acc = neg ? -$signed(q[31:0]) : $signed(q[31:0]);
    end
  endfunction

  function automatic void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_TARGET:     r_target = data;
      CFG_MAX_VEL:    r_vmax   = data[30:0];
      CFG_MAX_ACC:    r_amax   = data[30:0];
      CFG_MAX_VOLT:   r_volt   = data[15:0];
      CFG_BEMF:       r_bemf   = data[15:0];
      CFG_TIME_SCALE: r_tscale = data[15:0];
      default: ;
    endcase
    rebuild_profile();
  endfunction

  // Advance elapsed time by one tick word and work out its feedforward word.
  function automatic tpf_out_t advance_tick(tpf_in_t w);
    logic [63:0]        e, t, vmax, amag, m;
    logic signed [63:0] a64, v, drive;
    logic [1:0]         ph;
    tpf_out_t           r;
    e = w.restart ? 64'd0 : {32'd0, elapsed};
    e = e + {48'd0, w.tick_time};
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    elapsed = e[31:0];
    t    = {32'd0, move_ticks};
    vmax = nonzero({33'd0, r_vmax});
    a64  = prof_acc;
    amag = (a64 < 0) ? -a64 : a64;
    if (64'd3 * e < t) begin
      ph = PH_ACCEL;
      m  = amag * e;
    end else if (64'd3 * e < 64'd2 * t) begin
      ph = PH_CRUISE;
      m  = amag * t / 64'd3;
    end else if (e < t) begin
      ph = PH_DECEL;
      m  = amag * (t - e);
    end else begin
      ph = PH_PAST;
      m  = 64'd0;
    end
    if (m > vmax) m = vmax;
    v = $signed(m);
    if (a64 < 0) v = -v;
    // each term truncates toward zero on its own
    drive = v * Q12One / $signed(vmax)
          + a64 * Q12One / $signed(nonzero({33'd0, r_amax}))
          + $signed({48'd0, r_bemf}) * Q12One / $signed(nonzero({48'd0, r_volt}));
    if (drive > DriveMax) drive = DriveMax;
    if (drive < DriveMin) drive = DriveMin;
    r.drive_level     = drive[15:0];
    r.velocity_target = v[31:0];
    r.phase           = ph;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tpf_out_t want;
    if (!rst_ni) begin
      r_target = '0;
      r_vmax   = 31'd65536;
      r_amax   = 31'd65536;
      r_volt   = 16'd12000;
      r_bemf   = '0;
      r_tscale = 16'd1000;
      elapsed  = '0;
      rebuild_profile();
      drive_q.delete();
      errors = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_i) drive_q.push_back(advance_tick(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (drive_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, got drive %0d vel %0d phase %0d",
                   $time, out_data_i.drive_level, out_data_i.velocity_target,
                   out_data_i.phase);
        end else begin
          want = drive_q.pop_front();
          if (out_data_i.drive_level !== want.drive_level ||
              out_data_i.velocity_target !== want.velocity_target ||
              out_data_i.phase !== want.phase) begin
            errors++;
            $display("%0t: mismatch: expected drive %0d vel %0d phase %0d, got %0d %0d %0d",
                     $time, want.drive_level, want.velocity_target, want.phase,
                     out_data_i.drive_level, out_data_i.velocity_target, out_data_i.phase);
          end
        end
      end
      pending_o <= drive_q.size();
      errors_o  <= errors;
    end
  end

endmodule

FILE: tb/sv/trapezoidal_profile_feedforward_test.sv
`timescale 1ns / 1ps
// Top of the trapezoidal_profile_feedforward testbench: clock, reset, register setups, tick words
// and the feedforward sink; checking is done by tpf_feedforward_checker.
// Depends on tpf_pkg, trapezoidal_profile_feedforward and tpf_feedforward_checker.
module trapezoidal_profile_feedforward_test;
  import tpf_pkg::*;

  // Register indexes with no register behind them; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_SPARE     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_TOP = 3'd7;

  localparam int RandomSetups = 8;
  localparam int TicksPerSetup = 160;
  // Ticks of the last stretch; enough to run well past the end of its move.
  localparam int CalmTicks = 100;

  logic                clk_i;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tpf_in_t             in_data;
  logic                out_valid;
  logic                out_ready;
  tpf_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                calm;     // last stretch: neither side idles
  int                  pending;  // feedforward words still owed by the block
  int                  fails;

  trapezoidal_profile_feedforward i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tpf_feedforward_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run (every word waiting out the longest gaps on both
  // sides, every register rebuild and the two long sink holds).
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one tick word and hold it until accepted. Valid is left high so that a
  // following word can go out back to back; gaps lower it explicitly.
  task automatic send_tick(input logic restart, input logic [15:0] dt);
    in_valid <= 1'b1;
    in_data  <= '{restart: restart, tick_time: dt};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic idle_in(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop valid and wait until every feedforward word owed has come out, so the
  // block is idle before registers change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One register write per cycle; the enable is only lowered after the last one.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic [31:0] tgt, input logic [31:0] vmax,
                             input logic [31:0] amax, input logic [31:0] volt,
                             input logic [31:0] bemf, input logic [31:0] tscale);
    put_reg(CFG_TARGET, tgt);
    put_reg(CFG_MAX_VEL, vmax);
    put_reg(CFG_MAX_ACC, amax);
    put_reg(CFG_MAX_VOLT, volt);
    put_reg(CFG_BEMF, bemf);
    put_reg(CFG_TIME_SCALE, tscale);
    // a stray write to an unmapped index must leave everything alone
    put_reg($urandom_range(0, 1) ? CFG_SPARE : CFG_SPARE_TOP, $urandom());
    cfg_we <= 1'b0;
  endtask

  // Random register set. Half the time the move time is kept short enough that
  // the ticks of one setup walk through all four phases; otherwise anything goes,
  // including zero limits and zero time scale. Unused upper data bits carry junk.
  task automatic random_setup();
    logic [31:0] tgt, vel, acc, junk;
    logic [15:0] volt, bemf, ts;
    tgt = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) tgt = -tgt;
    vel  = $urandom() >> $urandom_range(1, 31);
    acc  = $urandom() >> $urandom_range(1, 31);
    volt = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    bemf = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 65535));
    ts   = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    if ($urandom_range(0, 1)) begin
      vel = (tgt[31] ? -tgt : tgt) >> $urandom_range(0, 6);
      if (vel == 0) vel = 32'd1;
      ts  = 16'($urandom_range(1, 200));
    end
    junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
    apply_setup(tgt, vel | (junk & 32'h8000_0000), acc | (junk & 32'h8000_0000),
                {junk[31:16], volt}, {junk[15:0], bemf}, {junk[23:8], ts});
  endtask

  // Feedforward sink. Random stall bursts, except in one of every three windows of
  // 128 words and in the last stretch. At two points it holds off for a long run of
  // cycles while the sender keeps offering, so the block backs up into its input.
  initial begin : sink
    int unsigned seen;
    int unsigned holds;
    seen  = 0;
    holds = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) seen++;
      if (holds < 2 && seen >= 300 + 600 * holds) begin
        holds++;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        out_ready <= 1'b1;
      end else if (!calm && (seen / 128) % 3 != 0 && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stim
    int unsigned gap_pct;
    int unsigned span;
    logic        restart;
    logic [15:0] dt;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_TARGET;
    cfg_wdata <= '0;
    calm      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero target means zero move time, so every word is past end
    // with no acceleration.
    send_tick(1'b1, 16'd0);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'd1);
    send_tick(1'b1, 16'd7);
    drain();

    // Four-tick move from the largest target; acceleration clamped to its limit.
    // Unit ticks step through accelerate, cruise, decelerate, past end.
    apply_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1000, 32'd65535, 32'd65535, 32'd1);
    send_tick(1'b1, 16'd0);
    repeat (5) send_tick(1'b0, 16'd1);
    send_tick(1'b1, 16'd2);
    drain();

    // Most negative target with limits and voltage written as zero (act as one):
    // move time saturates and the back emf term pins the drive high.
    apply_setup(32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd65535, 32'd65535);
    send_tick(1'b1, 16'd0);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'd1);
    drain();

    // Negative move of 10.0 with T = 135: ticks land exactly on T/3, 2T/3 and T.
    apply_setup(32'hFFF6_0000, 32'd65536, 32'h7FFF_FFFF, 32'd12000, 32'd0, 32'd3);
    send_tick(1'b1, 16'd10);
    send_tick(1'b0, 16'd35);
    send_tick(1'b0, 16'd45);
    send_tick(1'b0, 16'd44);
    send_tick(1'b0, 16'd1);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'd0);
    drain();

    // Random setups, each followed by a run of ticks starting with a restart.
    for (int s = 0; s < RandomSetups; s++) begin
      random_setup();
      gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
      send_tick(1'b1, 16'($urandom_range(0, 15)));
      repeat (TicksPerSetup) begin
        if ($urandom_range(0, 99) < gap_pct) idle_in($urandom_range(1, 14));
        span    = (1 << (4 * $urandom_range(0, 4))) - 1;
        restart = $urandom_range(0, 23) == 0;
        dt      = $urandom_range(0, 15) == 0 ? 16'($urandom()) : 16'($urandom_range(0, span));
        send_tick(restart, dt);
      end
      drain();
    end

    // Last stretch, no idling: a move of T = 900 ticks with a = 11930 per tick,
    // walked in steps of 20 through all four phases and well past the end.
    calm <= 1'b1;
    apply_setup(32'h7FFF_FFFF, 32'd10737418, 32'd65536, 32'd12000, 32'd1500, 32'd1);
    send_tick(1'b1, 16'd20);
    repeat (CalmTicks) send_tick(1'b0, 16'd20);
    drain();
    repeat (40) @(posedge clk_i);

    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tpf_pkg.sv
sv/tpf_div.sv
sv/trapezoidal_profile_feedforward.sv
tb/sv/tpf_feedforward_checker.sv
tb/sv/trapezoidal_profile_feedforward_test.sv
